@@ src/rob_pkg.sv @@
package rob_pkg;

  localparam int unsigned AddrW  = 19;
  localparam int unsigned PitchW = 12;
  localparam int unsigned CoordW = 11;
  localparam int unsigned DimW   = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 19;
  localparam logic [DimW-1:0] MaxDim = 12'd2048;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_BLIT  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ROP_COPY   = 4'd0,
    ROP_AND    = 4'd1,
    ROP_XOR    = 4'd2,
    ROP_CLEAR  = 4'd3,
    ROP_INVERT = 4'd4
  } rop_e;

  typedef enum logic [1:0] {
    CFG_SRC_BASE  = 2'd0,
    CFG_SRC_PITCH = 2'd1,
    CFG_DST_BASE  = 2'd2,
    CFG_DST_PITCH = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [AddrW-1:0]  byte_addr;
    logic [7:0]        write_byte;
    logic [CoordW-1:0] src_col;
    logic [CoordW-1:0] src_row;
    logic [CoordW-1:0] dst_col;
    logic [CoordW-1:0] dst_row;
    logic [DimW-1:0]   rect_width;
    logic [DimW-1:0]   rect_height;
    logic [3:0]        rop;
  } req_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              status;
    logic [CoordW-1:0] box_left;
    logic [CoordW-1:0] box_top;
    logic [DimW-1:0]   box_right;
    logic [DimW-1:0]   box_bottom;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]        kind;
    logic              bad_rop;
    logic              descend;
    logic [3:0]        rop;
    logic [AddrW-1:0]  byte_addr;
    logic [7:0]        write_byte;
    logic [CoordW-1:0] src_col;
    logic [CoordW-1:0] src_row;
    logic [CoordW-1:0] dst_col;
    logic [CoordW-1:0] dst_row;
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
  } cmd_t;

endpackage

@@ src/rob_stream_if.sv @@
interface rob_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/rob_cfg_if.sv @@
interface rob_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [18:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/rob_front.sv @@
module rob_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rob_pkg::req_t     in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output rob_pkg::cmd_t     cmd_o
);
  import rob_pkg::*;

  // two-entry queue towards the back end
  cmd_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  logic       push, pop;

  // classify the beat: clamp size, pick walk direction, flag bad mode
  always_comb begin
    cmd_new            = '0;
    cmd_new.kind       = in_data_i.req_type;
    cmd_new.bad_rop    = (in_data_i.rop > ROP_INVERT);
    cmd_new.descend    = !((in_data_i.src_row > in_data_i.dst_row) ||
                           ((in_data_i.src_row == in_data_i.dst_row) &&
                            (in_data_i.src_col >= in_data_i.dst_col)));
    cmd_new.rop        = in_data_i.rop;
    cmd_new.byte_addr  = in_data_i.byte_addr;
    cmd_new.write_byte = in_data_i.write_byte;
    cmd_new.src_col    = in_data_i.src_col;
    cmd_new.src_row    = in_data_i.src_row;
    cmd_new.dst_col    = in_data_i.dst_col;
    cmd_new.dst_row    = in_data_i.dst_row;
    cmd_new.width      = (in_data_i.rect_width > MaxDim) ? MaxDim : in_data_i.rect_width;
    cmd_new.height     = (in_data_i.rect_height > MaxDim) ? MaxDim : in_data_i.rect_height;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // hold queued payload
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd_new;
  end

endmodule

@@ src/rob_back.sv @@
module rob_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  rob_pkg::cmd_t         cmd_i,
  input  logic [18:0]           src_base_i,
  input  logic [11:0]           src_pitch_i,
  input  logic [18:0]           dst_base_i,
  input  logic [11:0]           dst_pitch_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rob_pkg::rsp_t         out_data_o
);
  import rob_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ORIGIN, ST_RDSRC, ST_RDDST, ST_WRITE, ST_READ, ST_RESP
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [7:0]        mem [524288];
  logic [7:0]        rd_q;
  logic [7:0]        src_pix_q;
  logic [AddrW-1:0]  s_row_q, d_row_q, s_addr_q, d_addr_q;
  logic [DimW-1:0]   row_left_q, col_left_q;
  logic              out_valid_q;
  rsp_t              rsp_q;
  logic [AddrW-1:0]  mem_raddr;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        new_pix;
  logic [AddrW+PitchW-1:0] s_off, d_off;
  logic [AddrW-1:0]  s_org, d_org;
  logic [AddrW-1:0]  s_far, d_far;
  logic [AddrW-1:0]  s_step, d_step, s_next_row, d_next_row;
  logic [DimW-1:0]   w_m1, h_m1;

  assign cmd_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  assign w_m1 = cmd_q.width - 1'b1;
  assign h_m1 = cmd_q.height - 1'b1;

  // origin: base + col + row * pitch, and the far corner for a descending walk
  always_comb begin
    s_off = {{(AddrW+PitchW-CoordW){1'b0}}, cmd_q.src_row} * {{AddrW{1'b0}}, src_pitch_i};
    d_off = {{(AddrW+PitchW-CoordW){1'b0}}, cmd_q.dst_row} * {{AddrW{1'b0}}, dst_pitch_i};
    s_org = src_base_i + {{(AddrW-CoordW){1'b0}}, cmd_q.src_col} + s_off[AddrW-1:0];
    d_org = dst_base_i + {{(AddrW-CoordW){1'b0}}, cmd_q.dst_col} + d_off[AddrW-1:0];
    s_far = AddrW'({{(AddrW-DimW){1'b0}}, h_m1} * {{(AddrW-PitchW){1'b0}}, src_pitch_i});
    d_far = AddrW'({{(AddrW-DimW){1'b0}}, h_m1} * {{(AddrW-PitchW){1'b0}}, dst_pitch_i});
  end

  // step along a row and to the next row
  always_comb begin
    s_step = cmd_q.descend ? s_addr_q - 1'b1 : s_addr_q + 1'b1;
    d_step = cmd_q.descend ? d_addr_q - 1'b1 : d_addr_q + 1'b1;
    s_next_row = cmd_q.descend ? s_row_q - {{(AddrW-PitchW){1'b0}}, src_pitch_i}
                               : s_row_q + {{(AddrW-PitchW){1'b0}}, src_pitch_i};
    d_next_row = cmd_q.descend ? d_row_q - {{(AddrW-PitchW){1'b0}}, dst_pitch_i}
                               : d_row_q + {{(AddrW-PitchW){1'b0}}, dst_pitch_i};
  end

  // combine destination with source
  always_comb begin
    case (cmd_q.rop)
      ROP_COPY:  new_pix = src_pix_q;
      ROP_AND:   new_pix = rd_q & src_pix_q;
      ROP_XOR:   new_pix = rd_q ^ src_pix_q;
      ROP_CLEAR: new_pix = 8'd0;
      default:   new_pix = ~rd_q;
    endcase
  end

  always_comb begin
    mem_raddr = d_addr_q;
    if (state_q == ST_RDSRC) mem_raddr = s_addr_q;
    if (state_q == ST_IDLE) mem_raddr = cmd_i.byte_addr;
    mem_we    = 1'b0;
    mem_waddr = d_addr_q;
    mem_wdata = new_pix;
    if (state_q == ST_WRITE) mem_we = 1'b1;
    if (state_q == ST_IDLE && cmd_valid_i && cmd_ready_o &&
        cmd_i.kind == REQ_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = cmd_i.byte_addr;
      mem_wdata = cmd_i.write_byte;
    end
  end

  // pixel store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // sequence each command; drop the result beat when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (cmd_valid_i && cmd_ready_o) begin
          cmd_q <= cmd_i;
          rsp_q <= '0;
          unique case (cmd_i.kind)
            REQ_READ: state_q <= ST_READ;
            REQ_BLIT: begin
              if (cmd_i.bad_rop) begin
                rsp_q.status <= 1'b1;
                out_valid_q  <= 1'b1;
              end else begin
                state_q <= ST_ORIGIN;
              end
            end
            default: out_valid_q <= 1'b1;
          endcase
        end
        ST_READ: begin
          rsp_q.read_byte <= rd_q;
          out_valid_q     <= 1'b1;
          state_q         <= ST_IDLE;
        end
        ST_ORIGIN: begin
          rsp_q.box_left   <= cmd_q.dst_col;
          rsp_q.box_top    <= cmd_q.dst_row;
          rsp_q.box_right  <= {1'b0, cmd_q.dst_col} + cmd_q.width;
          rsp_q.box_bottom <= {1'b0, cmd_q.dst_row} + cmd_q.height;
          row_left_q <= cmd_q.height;
          col_left_q <= cmd_q.width;
          if (cmd_q.descend) begin
            s_row_q  <= s_org + s_far;
            d_row_q  <= d_org + d_far;
            s_addr_q <= s_org + s_far + AddrW'(w_m1);
            d_addr_q <= d_org + d_far + AddrW'(w_m1);
          end else begin
            s_row_q  <= s_org;
            d_row_q  <= d_org;
            s_addr_q <= s_org;
            d_addr_q <= d_org;
          end
          if (cmd_q.width == '0 || cmd_q.height == '0) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_RDSRC;
          end
        end
        ST_RDSRC: state_q <= ST_RDDST;
        ST_RDDST: begin
          src_pix_q <= rd_q;
          state_q   <= ST_WRITE;
        end
        ST_WRITE: begin
          if (col_left_q != 12'd1) begin
            col_left_q <= col_left_q - 1'b1;
            s_addr_q   <= s_step;
            d_addr_q   <= d_step;
            state_q    <= ST_RDSRC;
          end else if (row_left_q != 12'd1) begin
            row_left_q <= row_left_q - 1'b1;
            col_left_q <= cmd_q.width;
            s_row_q    <= s_next_row;
            d_row_q    <= d_next_row;
            s_addr_q   <= cmd_q.descend ? s_next_row + AddrW'(w_m1) : s_next_row;
            d_addr_q   <= cmd_q.descend ? d_next_row + AddrW'(w_m1) : d_next_row;
            state_q    <= ST_RDSRC;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/raster_op_block_blitter_unit.sv @@
// channel | dir | beat
// in_if   | in  | req_type, byte_addr, write_byte, rect fields, rop
// out_if  | out | read_byte, status, box_left/top/right/bottom
// cfg_if  | in  | index 0..3, data
// Write: done in the back end as the command is taken; read: a registered store read;
// blit: an origin step, then a source read, dest read and write per pixel (one read port).
// Reset clears control only; the pixel store holds no reset value.
// The front queue takes up to two beats while the back end runs or the result waits.
module raster_op_block_blitter_unit (
  input logic   clk_i,
  input logic   rst_ni,
  rob_stream_if.sink   in_if,
  rob_stream_if.source out_if,
  rob_cfg_if.sink      cfg_if
);
  import rob_pkg::*;

  logic [18:0] src_base_q, dst_base_q;
  logic [11:0] src_pitch_q, dst_pitch_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  assign cfg_if.ready = 1'b1;

  // capture register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base_q  <= '0;
      src_pitch_q <= 12'd640;
      dst_base_q  <= '0;
      dst_pitch_q <= 12'd640;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_SRC_BASE:  src_base_q  <= cfg_if.data;
        CFG_SRC_PITCH: src_pitch_q <= cfg_if.data[11:0];
        CFG_DST_BASE:  dst_base_q  <= cfg_if.data;
        default:       dst_pitch_q <= cfg_if.data[11:0];
      endcase
    end
  end

  rob_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_data_i  (in_if.data),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  rob_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .src_base_i (src_base_q),
    .src_pitch_i(src_pitch_q),
    .dst_base_i (dst_base_q),
    .dst_pitch_i(dst_pitch_q),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_data_o (out_if.data)
  );

endmodule

@@ src/rob_checker.sv @@
module rob_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rob_pkg::rsp_t out_data
);
  import rob_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("request beat withdrawn while stalled");

  a_skip_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status |-> out_data.box_right == '0 && out_data.read_byte == '0)
    else $error("skipped blit carries data");

  a_box_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.read_byte != '0 |-> out_data.box_bottom == '0)
    else $error("read result carries box");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind raster_op_block_blitter_unit rob_checker u_rob_checker (
  .clk_i, .rst_ni,
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_data (out_if.data)
);
